// ===== design/adaptive_notch_frequency_tracker_defines.svh =====
// Assertion macros used by the checker file.
`ifndef ADAPTIVE_NOTCH_FREQUENCY_TRACKER_DEFINES_SVH
`define ADAPTIVE_NOTCH_FREQUENCY_TRACKER_DEFINES_SVH

// Implication checked in the same cycle.
`define ANFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define ANFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/anft_pkg.sv =====
package anft_pkg;

  localparam int unsigned PI_Q14 = 51472;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam logic [15:0] ANGLE_RST = 16'd25736;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEP_SIZE = 2'd0;
  localparam logic [1:0] CFG_INIT_ANGLE = 2'd1;
  localparam logic [1:0] CFG_POLE_RADIUS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_DIV, ST_TRIG, ST_MAC, ST_DRAIN, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_RC, OP_RR, OP_RS, OP_CX, OP_RCY, OP_RRY, OP_SX,
    OP_RSY, OP_RCG, OP_RRG, OP_ROUND, OP_MG, OP_YLO, OP_YHI, OP_ANGLE
  } op_t;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PROG_LAST = 5'd17;

  typedef struct packed {
    logic capture;
    logic div_load;
    logic div_step;
    logic trig_load;
    op_t  op;
    logic out_load;
  } ctrl_cmd_t;

  // Micro-program of the shared multiplier; NOP steps wait for the ROUND and MG results
  function automatic op_t op_at(input logic [PC_W-1:0] pc);
    op_t op;
    unique case (pc)
      5'd0:    op = OP_LOAD;
      5'd1:    op = OP_RC;
      5'd2:    op = OP_RR;
      5'd3:    op = OP_RS;
      5'd4:    op = OP_CX;
      5'd5:    op = OP_RCY;
      5'd6:    op = OP_RRY;
      5'd7:    op = OP_SX;
      5'd8:    op = OP_RSY;
      5'd9:    op = OP_RCG;
      5'd10:   op = OP_RRG;
      5'd11:   op = OP_ROUND;
      5'd13:   op = OP_MG;
      5'd15:   op = OP_YLO;
      5'd16:   op = OP_YHI;
      5'd17:   op = OP_ANGLE;
      default: op = OP_NOP;
    endcase
    return op;
  endfunction

  // Sine of pi*k/2^tbits in Q1.15 by a Q30 Taylor series, rounded half up
  function automatic logic [15:0] sin_q15(input int unsigned k, input int unsigned tbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned q;
    x = (PI_Q30 * longint'(k) + ((64'd1 << tbits) >> 1)) >> tbits;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    for (int i = 0; i < 6; i++) begin
      q = (x2 * t) >> 30;
      unique case (i)
        0:       q = q / 156;
        1:       q = q / 110;
        2:       q = q / 72;
        3:       q = q / 42;
        4:       q = q / 20;
        default: q = q / 6;
      endcase
      t = Q30_ONE - q;
    end
    return 16'((((x * t) >> 30) + 64'd16384) >> 15);
  endfunction

endpackage

// ===== design/anft_ctrl.sv =====
module anft_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output anft_pkg::ctrl_cmd_t  cmd
);
  import anft_pkg::*;

  localparam int CNT_W = 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequence one transaction through divide, lookup, multiply and output
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '{capture: 1'b0, div_load: 1'b0, div_step: 1'b0,
                      trig_load: 1'b0, op: OP_NOP, out_load: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = ST_TRIG;
      end
      ST_TRIG: begin
        cmd.trig_load = 1'b1;
        pc_nxt        = '0;
        state_nxt     = ST_MAC;
      end
      ST_MAC: begin
        cmd.op = op_at(pc_r);
        pc_nxt = pc_r + 1'b1;
        if (pc_r == PROG_LAST) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== design/anft_dp.sv =====
module anft_dp #(
  parameter int TRIG_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  anft_pkg::ctrl_cmd_t           cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_restart,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_addr,
  input  logic [15:0]                   cfg_wdata,
  output logic [15:0]                   out_angle_estimate,
  output logic signed [23:0]            out_notch_out
);
  import anft_pkg::*;

  localparam int T        = TRIG_TABLE_BITS;
  localparam int FRAC     = SAMPLE_BITS - 1;
  localparam int TAB_N    = 1 << T;
  localparam int TAB_HALF = TAB_N >> 1;
  localparam int REM_W    = 17 + T;
  localparam int RCP_W    = T + 2;
  localparam int K_W      = T + 1;
  localparam int ACC_W    = 62;
  localparam int P_W      = 64;
  localparam longint unsigned RCP_FULL = (64'd1 << REM_W) / PI_Q14;
  localparam logic [RCP_W-1:0] DIV_RCP = RCP_W'(RCP_FULL);
  localparam logic [REM_W-1:0] DIV_PI  = REM_W'(PI_Q14);
  localparam logic [REM_W-1:0] DIV_RND = REM_W'(PI_Q14 / 2);

  typedef logic [15:0] tab_t [0:TAB_HALF];

  function automatic tab_t build_tab();
    tab_t tb;
    for (int k = 0; k <= TAB_HALF; k++) tb[k] = sin_q15(k, T);
    return tb;
  endfunction

  localparam tab_t SIN_TAB = build_tab();

  function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [23:0] res;
    if (v > ACC_W'(24'sh7fffff)) res = 24'sh7fffff;
    else if (v < -(ACC_W'(64'sd8388608))) res = 24'sh800000;
    else res = v[23:0];
    return res;
  endfunction

  // Configuration
  logic [15:0] step_r, init_r, pole_r;

  // Item state
  logic signed [SAMPLE_BITS-1:0] x_r, x1_r, x2_r;
  logic signed [23:0]            y1_r, y2_r, g1_r, g2_r, y_r, g_r;
  logic [15:0]                   angle_r;

  // Divider and lookup
  logic [REM_W-1:0]       num_r, krem;
  logic [REM_W+RCP_W-1:0] qprod;
  logic [K_W-1:0]         k_r, kest_r, kest, s_idx, c_idx;
  logic                   k_up, k_lo;
  logic [15:0]            s_r, craw_r;
  logic                   cneg_r;

  // Multiplier and accumulators
  logic signed [33:0]      mul_a;
  logic signed [24:0]      mul_b;
  logic signed [58:0]      prod_r;
  op_t                     op_d_r;
  logic signed [33:0]      rc_r, rs_r;
  logic [31:0]             rr_r;
  logic signed [40:0]      mg_r;
  logic signed [ACC_W-1:0] acc_y_r, acc_g_r;
  logic signed [P_W-1:0]   acc_p_r, delta, ang_new;
  logic signed [16:0]      c_val, s_val;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 16'd655;
      init_r <= ANGLE_RST;
      pole_r <= 16'd55706;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_STEP_SIZE:   step_r <= cfg_wdata;
        CFG_INIT_ANGLE:  init_r <= cfg_wdata;
        CFG_POLE_RADIUS: pole_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Table index: reciprocal estimate, at most one short, then one correcting compare
  assign qprod = num_r * DIV_RCP;
  assign kest  = qprod[REM_W +: K_W];
  assign krem  = num_r - (REM_W'(kest_r) * DIV_PI);
  assign k_up  = (krem >= DIV_PI);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      num_r  <= (REM_W'(angle_r) << T) + DIV_RND;
      kest_r <= '0;
      k_r    <= '0;
    end else if (cmd.div_step) begin
      kest_r <= kest;
      k_r    <= kest_r + K_W'(k_up);
    end
  end

  // Quarter-wave table read, registered
  assign k_lo  = (k_r <= K_W'(TAB_HALF));
  assign s_idx = k_lo ? k_r : K_W'(TAB_N) - k_r;
  assign c_idx = k_lo ? K_W'(TAB_HALF) - k_r : k_r - K_W'(TAB_HALF);

  always_ff @(posedge clk) begin
    if (cmd.trig_load) begin
      s_r    <= SIN_TAB[s_idx[T-1:0]];
      craw_r <= SIN_TAB[c_idx[T-1:0]];
      cneg_r <= !k_lo;
    end
  end

  assign s_val = signed'({1'b0, s_r});
  assign c_val = cneg_r ? -signed'({1'b0, craw_r}) : signed'({1'b0, craw_r});

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_RC:  begin mul_a = 34'(signed'({1'b0, pole_r})); mul_b = 25'(c_val); end
      OP_RR:  begin
        mul_a = 34'(signed'({1'b0, pole_r}));
        mul_b = 25'(signed'({1'b0, pole_r}));
      end
      OP_RS:  begin mul_a = 34'(signed'({1'b0, pole_r})); mul_b = 25'(s_val); end
      OP_CX:  begin mul_a = 34'(c_val); mul_b = 25'(x1_r); end
      OP_RCY: begin mul_a = rc_r; mul_b = 25'(y1_r); end
      OP_RRY: begin mul_a = 34'(signed'({1'b0, rr_r})); mul_b = 25'(y2_r); end
      OP_SX:  begin mul_a = 34'(s_val); mul_b = 25'(x1_r); end
      OP_RSY: begin mul_a = rs_r; mul_b = 25'(y1_r); end
      OP_RCG: begin mul_a = rc_r; mul_b = 25'(g1_r); end
      OP_RRG: begin mul_a = 34'(signed'({1'b0, rr_r})); mul_b = 25'(g2_r); end
      OP_MG:  begin mul_a = 34'(signed'({1'b0, step_r})); mul_b = 25'(g_r); end
      OP_YLO: begin mul_a = 34'(signed'({1'b0, mg_r[19:0]})); mul_b = 25'(y_r); end
      OP_YHI: begin mul_a = 34'($signed(mg_r[40:20])); mul_b = 25'(y_r); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) op_d_r <= OP_NOP;
    else op_d_r <= cmd.op;
  end

  // Angle step from the rounded product mu*y*g
  assign delta   = (acc_p_r + (P_W'(1) <<< (2 * FRAC))) >>> (2 * FRAC + 1);
  assign ang_new = P_W'(signed'({1'b0, angle_r})) - delta;

  // Capture, accumulate and commit the filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= ANGLE_RST;
      x1_r    <= '0;
      x2_r    <= '0;
      y1_r    <= '0;
      y2_r    <= '0;
      g1_r    <= '0;
      g2_r    <= '0;
    end else if (cmd.capture) begin
      x_r <= in_sample;
      if (in_restart) begin
        angle_r <= (init_r > 16'(PI_Q14)) ? 16'(PI_Q14) : init_r;
        x1_r    <= '0;
        x2_r    <= '0;
        y1_r    <= '0;
        y2_r    <= '0;
        g1_r    <= '0;
        g2_r    <= '0;
      end
    end else begin
      unique case (op_d_r)
        OP_LOAD: begin
          acc_y_r <= (ACC_W'(x_r) + ACC_W'(x2_r)) <<< 32;
          acc_g_r <= '0;
        end
        OP_RC:    rc_r    <= prod_r[33:0];
        OP_RR:    rr_r    <= prod_r[31:0];
        OP_RS:    rs_r    <= prod_r[33:0];
        OP_CX:    acc_y_r <= acc_y_r - (ACC_W'(prod_r) <<< 18);
        OP_RCY:   acc_y_r <= acc_y_r + (ACC_W'(prod_r) <<< 2);
        OP_RRY:   acc_y_r <= acc_y_r - ACC_W'(prod_r);
        OP_SX:    acc_g_r <= acc_g_r + (ACC_W'(prod_r) <<< 18);
        OP_RSY:   acc_g_r <= acc_g_r - (ACC_W'(prod_r) <<< 2);
        OP_RCG:   acc_g_r <= acc_g_r + (ACC_W'(prod_r) <<< 2);
        OP_RRG:   acc_g_r <= acc_g_r - ACC_W'(prod_r);
        OP_ROUND: begin
          y_r <= sat24((acc_y_r + (ACC_W'(1) <<< 31)) >>> 32);
          g_r <= sat24((acc_g_r + (ACC_W'(1) <<< 31)) >>> 32);
        end
        OP_MG:    mg_r    <= prod_r[40:0];
        OP_YLO:   acc_p_r <= P_W'(prod_r);
        OP_YHI:   acc_p_r <= acc_p_r + (P_W'(prod_r) <<< 20);
        OP_ANGLE: begin
          if (ang_new < 0) angle_r <= '0;
          else if (ang_new > P_W'(PI_Q14)) angle_r <= 16'(PI_Q14);
          else angle_r <= ang_new[15:0];
          x2_r <= x1_r;
          x1_r <= x_r;
          y2_r <= y1_r;
          y1_r <= y_r;
          g2_r <= g1_r;
          g1_r <= g_r;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_angle_estimate <= angle_r;
      out_notch_out      <= y1_r;
    end
  end

endmodule

// ===== design/adaptive_notch_frequency_tracker.sv =====
// Channel   Handshake             Payload
// in        in_valid / in_stall   in_sample, in_restart
// out       out_valid / out_stall out_angle_estimate, out_notch_out
// cfg       cfg_wr_en             cfg_addr, cfg_wdata
//
// Each transaction runs from acceptance to result through a two-step
// reciprocal divide for the table index, a table read, one shared 34x25
// multiplier working through eighteen program steps, a commit and the output load.
// The input reopens as the result appears, so transactions never overlap.
// Reset is synchronous; the result waits in an output register, and a stalled
// result holds back only the final load of the next transaction.
module adaptive_notch_frequency_tracker #(
  parameter int TRIG_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_angle_estimate,
  output logic signed [23:0]            out_notch_out,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_addr,
  input  logic [15:0]                   cfg_wdata
);
  import anft_pkg::*;

  ctrl_cmd_t cmd;

  anft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  anft_dp #(
    .TRIG_TABLE_BITS (TRIG_TABLE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_sample          (in_sample),
    .in_restart         (in_restart),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .out_angle_estimate (out_angle_estimate),
    .out_notch_out      (out_notch_out)
  );

endmodule

// ===== design/anft_checker.sv =====
`include "adaptive_notch_frequency_tracker_defines.svh"

module anft_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_angle_estimate,
  input logic [23:0] out_notch_out
);

  // One transaction at a time: input closes right after acceptance
  `ANFT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after accept")
  // Angle never leaves [0, pi]
  `ANFT_ASSERT_NOW(a_angle_range, out_valid, out_angle_estimate <= 16'd51472, "angle beyond pi")
  // Stalled result holds
  `ANFT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_notch_out), "result dropped")
  // No result while the input side is still open and idle
  `ANFT_ASSERT_NEXT(a_no_spurious, !out_valid && !in_stall, !out_valid, "result without transaction")

endmodule

bind adaptive_notch_frequency_tracker anft_checker u_anft_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_angle_estimate (out_angle_estimate),
  .out_notch_out      (out_notch_out)
);
